// ===== rtl/cteq_pkg.sv =====
// Shared types, codes and defaults of the cancellable timer event queue.
package cteq_pkg;

  localparam int unsigned QueueDepthDef = 64;
  localparam int unsigned HandleBitsDef = 16;
  localparam int unsigned TimeBitsDef   = 48;
  localparam int unsigned IdBits        = 32;
  localparam logic [IdBits-1:0] IdMax   = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ACT_ADD      = 3'd0,
    ACT_CANCEL   = 3'd1,
    ACT_TICK     = 3'd2,
    ACT_START    = 3'd3,
    ACT_CLOSE    = 3'd4,
    ACT_SHUTDOWN = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    STS_OK          = 2'd0,
    STS_NOT_RUNNING = 2'd1,
    STS_FULL        = 2'd2,
    STS_NOT_FOUND   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FIRE_NONE = 2'd0,
    FIRE_RUN  = 2'd1,
    FIRE_DROP = 2'd2
  } fire_e;

  typedef enum logic [1:0] {
    RUN_TERMINATED = 2'd0,
    RUN_RUNNING    = 2'd1,
    RUN_CLOSING    = 2'd2
  } run_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN_ADD,
    S_SCAN_CAN,
    S_ROOT_CHK,
    S_SCAN_TICK,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RD,
    S_DN_CMP
  } fsm_e;

  typedef struct packed {
    logic    load;
    logic    gen_id;
    logic    scan_start;
    logic    mark;
    logic    clr_active;
    logic    root_read;
    logic    take;
    logic    up_read;
    logic    up_move;
    logic    up_place;
    logic    dn_read;
    logic    dn_move;
    logic    dn_place;
    logic    clear_all;
    logic    set_run;
    run_e    run;
    logic    finish;
    status_e status;
    fire_e   fire;
  } cmd_t;

  typedef struct packed {
    logic [2:0] act;
    run_e       run;
    logic       id_zero;
    logic       cnt_zero;
    logic       full;
    logic       scan_busy;
    logic       found;
    logic       at_root;
    logic       up_move;
    logic       due;
    logic       dn_leaf;
    logic       dn_move;
  } sts_t;

endpackage

// ===== rtl/cteq_ctrl.sv =====
// Controller state machine that sequences the id scan and the heap sifts.
module cteq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  cteq_pkg::sts_t  sts_i,
  output cteq_pkg::cmd_t  cmd_o
);

  cteq_pkg::fsm_e state_q, state_d;
  cteq_pkg::fire_e pop_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cteq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy     = (state_q != cteq_pkg::S_IDLE);
  assign pop_fire = sts_i.found ? cteq_pkg::FIRE_RUN : cteq_pkg::FIRE_DROP;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.status = cteq_pkg::STS_OK;
    cmd_o.fire   = cteq_pkg::FIRE_NONE;
    cmd_o.run    = cteq_pkg::RUN_TERMINATED;
    unique case (state_q)
      cteq_pkg::S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = cteq_pkg::S_DECODE;
        end
      end
      cteq_pkg::S_DECODE: begin
        state_d = cteq_pkg::S_IDLE;
        unique case (cteq_pkg::action_e'(sts_i.act))
          cteq_pkg::ACT_ADD: begin
            if (sts_i.run != cteq_pkg::RUN_RUNNING) begin
              cmd_o.finish = 1'b1;
              cmd_o.status = cteq_pkg::STS_NOT_RUNNING;
            end else if (sts_i.full) begin
              cmd_o.finish = 1'b1;
              cmd_o.status = cteq_pkg::STS_FULL;
            end else begin
              cmd_o.gen_id     = sts_i.id_zero;
              cmd_o.scan_start = 1'b1;
              state_d          = cteq_pkg::S_SCAN_ADD;
            end
          end
          cteq_pkg::ACT_CANCEL: begin
            if (sts_i.id_zero) begin
              cmd_o.finish = 1'b1;
              cmd_o.status = cteq_pkg::STS_NOT_FOUND;
            end else begin
              cmd_o.scan_start = 1'b1;
              state_d          = cteq_pkg::S_SCAN_CAN;
            end
          end
          cteq_pkg::ACT_TICK: begin
            if (sts_i.run == cteq_pkg::RUN_TERMINATED) begin
              cmd_o.finish = 1'b1;
              cmd_o.status = cteq_pkg::STS_NOT_RUNNING;
            end else if (sts_i.cnt_zero) begin
              cmd_o.finish = 1'b1;
            end else begin
              cmd_o.root_read = 1'b1;
              state_d         = cteq_pkg::S_ROOT_CHK;
            end
          end
          cteq_pkg::ACT_START: begin
            cmd_o.finish = 1'b1;
            if (sts_i.run == cteq_pkg::RUN_TERMINATED) begin
              cmd_o.set_run = 1'b1;
              cmd_o.run     = cteq_pkg::RUN_RUNNING;
            end else begin
              cmd_o.status = cteq_pkg::STS_NOT_RUNNING;
            end
          end
          cteq_pkg::ACT_CLOSE: begin
            cmd_o.finish  = 1'b1;
            cmd_o.set_run = 1'b1;
            cmd_o.run     = cteq_pkg::RUN_CLOSING;
          end
          cteq_pkg::ACT_SHUTDOWN: begin
            cmd_o.finish    = 1'b1;
            cmd_o.set_run   = 1'b1;
            cmd_o.run       = cteq_pkg::RUN_TERMINATED;
            cmd_o.clear_all = 1'b1;
          end
          default: begin
            cmd_o.finish = 1'b1;
          end
        endcase
      end
      cteq_pkg::S_SCAN_ADD: begin
        if (!sts_i.scan_busy) begin
          cmd_o.mark = 1'b1;
          state_d    = cteq_pkg::S_UP_RD;
        end
      end
      cteq_pkg::S_SCAN_CAN: begin
        if (!sts_i.scan_busy) begin
          cmd_o.finish     = 1'b1;
          cmd_o.clr_active = sts_i.found;
          cmd_o.status     = sts_i.found ? cteq_pkg::STS_OK : cteq_pkg::STS_NOT_FOUND;
          state_d          = cteq_pkg::S_IDLE;
        end
      end
      cteq_pkg::S_ROOT_CHK: begin
        if (sts_i.due) begin
          cmd_o.take       = 1'b1;
          cmd_o.scan_start = 1'b1;
          state_d          = cteq_pkg::S_SCAN_TICK;
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = cteq_pkg::S_IDLE;
        end
      end
      cteq_pkg::S_SCAN_TICK: begin
        if (!sts_i.scan_busy) begin
          cmd_o.clr_active = sts_i.found;
          state_d          = cteq_pkg::S_DN_RD;
        end
      end
      cteq_pkg::S_UP_RD: begin
        if (sts_i.at_root) begin
          cmd_o.up_place = 1'b1;
          cmd_o.finish   = 1'b1;
          state_d        = cteq_pkg::S_IDLE;
        end else begin
          cmd_o.up_read = 1'b1;
          state_d       = cteq_pkg::S_UP_CMP;
        end
      end
      cteq_pkg::S_UP_CMP: begin
        if (sts_i.up_move) begin
          cmd_o.up_move = 1'b1;
          state_d       = cteq_pkg::S_UP_RD;
        end else begin
          cmd_o.up_place = 1'b1;
          cmd_o.finish   = 1'b1;
          state_d        = cteq_pkg::S_IDLE;
        end
      end
      cteq_pkg::S_DN_RD: begin
        if (sts_i.dn_leaf) begin
          cmd_o.dn_place = 1'b1;
          cmd_o.finish   = 1'b1;
          cmd_o.fire     = pop_fire;
          state_d        = cteq_pkg::S_IDLE;
        end else begin
          cmd_o.dn_read = 1'b1;
          state_d       = cteq_pkg::S_DN_CMP;
        end
      end
      cteq_pkg::S_DN_CMP: begin
        if (sts_i.dn_move) begin
          cmd_o.dn_move = 1'b1;
          state_d       = cteq_pkg::S_DN_RD;
        end else begin
          cmd_o.dn_place = 1'b1;
          cmd_o.finish   = 1'b1;
          cmd_o.fire     = pop_fire;
          state_d        = cteq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = cteq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/cteq_datapath.sv =====
// Datapath: item registers, binary heap memory, active id store and result registers.
module cteq_datapath #(
  parameter int unsigned QueueDepth = cteq_pkg::QueueDepthDef,
  parameter int unsigned HandleBits = cteq_pkg::HandleBitsDef,
  parameter int unsigned TimeBits   = cteq_pkg::TimeBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cteq_pkg::cmd_t              cmd_i,
  output cteq_pkg::sts_t              sts_o,
  input  logic [2:0]                  action_i,
  input  logic [TimeBits-1:0]         deadline_i,
  input  logic [cteq_pkg::IdBits-1:0] event_id_in_i,
  input  logic [HandleBits-1:0]       task_handle_i,
  input  logic [TimeBits-1:0]         now_time_i,
  output logic                        done_o,
  output logic [1:0]                  status_o,
  output logic [cteq_pkg::IdBits-1:0] event_id_out_o,
  output logic [1:0]                  fire_kind_o,
  output logic [HandleBits-1:0]       fired_handle_o
);

  localparam int unsigned IdW  = cteq_pkg::IdBits;
  localparam int unsigned IdxW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam int unsigned ChW  = CntW + 1;

  typedef struct packed {
    logic [TimeBits-1:0]   dl;
    logic [IdW-1:0]        stamp;
    logic [IdW-1:0]        id;
    logic [HandleBits-1:0] hd;
  } entry_t;

  // Earlier deadline first; equal deadlines leave in insertion order.
  function automatic logic earlier(entry_t a, entry_t b);
    logic [IdW-1:0] diff;
    diff = a.stamp - b.stamp;
    return (a.dl < b.dl) || ((a.dl == b.dl) && diff[IdW-1]);
  endfunction

  entry_t heap_mem [QueueDepth];
  logic [IdW-1:0] ids_mem [QueueDepth];

  logic [2:0]            act_q;
  logic [TimeBits-1:0]   dl_q, now_q;
  logic [IdW-1:0]        id_q;
  logic [HandleBits-1:0] hd_q;
  logic [CntW-1:0]       count_q;
  cteq_pkg::run_e        run_q;
  logic [IdW-1:0]        last_gen_q, stamp_q;
  logic [QueueDepth-1:0] valid_q;
  entry_t                ra_q, rb_q, last_q;
  logic [IdxW-1:0]       pos_q;

  logic                  issuing_q, pv_q, found_q, hfree_q;
  logic [IdxW-1:0]       sidx_q, pidx_q, fidx_q, free_idx_q;
  logic [IdW-1:0]        rid_q;

  logic                  done_q;
  cteq_pkg::status_e     res_status_q;
  cteq_pkg::fire_e       res_kind_q;
  logic [IdW-1:0]        res_id_q;
  logic [HandleBits-1:0] res_hd_q;

  entry_t          nw, child, wdata;
  logic [IdxW-1:0] parent, cidx, ra_addr, rb_addr, waddr, last_idx;
  logic [ChW-1:0]  lch, rch, cnt_ext;
  logic            use_r, we;
  logic [IdW-1:0]  gen_next;

  assign nw       = '{dl: dl_q, stamp: stamp_q, id: id_q, hd: hd_q};
  assign parent   = (pos_q - IdxW'(1)) >> 1;
  assign lch      = (ChW'(pos_q) << 1) + ChW'(1);
  assign rch      = lch + ChW'(1);
  assign cnt_ext  = ChW'(count_q);
  assign use_r    = (rch < cnt_ext) && earlier(rb_q, ra_q);
  assign child    = use_r ? rb_q : ra_q;
  assign cidx     = use_r ? rch[IdxW-1:0] : lch[IdxW-1:0];
  assign last_idx = IdxW'(count_q - CntW'(1));
  assign gen_next = (last_gen_q == cteq_pkg::IdMax) ? IdW'(1) : last_gen_q + IdW'(1);

  always_comb begin
    ra_addr = '0;
    rb_addr = '0;
    if (cmd_i.up_read) begin
      ra_addr = parent;
    end else if (cmd_i.root_read) begin
      rb_addr = last_idx;
    end else if (cmd_i.dn_read) begin
      ra_addr = lch[IdxW-1:0];
      rb_addr = rch[IdxW-1:0];
    end
  end

  always_comb begin
    we    = 1'b1;
    waddr = pos_q;
    wdata = nw;
    if (cmd_i.up_move) begin
      wdata = ra_q;
    end else if (cmd_i.dn_move) begin
      wdata = child;
    end else if (cmd_i.dn_place) begin
      wdata = last_q;
    end else if (!cmd_i.up_place) begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      heap_mem[waddr] <= wdata;
    end
    ra_q <= heap_mem[ra_addr];
    rb_q <= heap_mem[rb_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mark && !found_q && hfree_q) begin
      ids_mem[free_idx_q] <= id_q;
    end
    rid_q <= ids_mem[sidx_q];
  end

  // Item payload and result payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q    <= action_i;
      dl_q     <= deadline_i;
      id_q     <= event_id_in_i;
      hd_q     <= task_handle_i;
      now_q    <= now_time_i;
      pos_q    <= count_q[IdxW-1:0];
      res_hd_q <= '0;
      res_id_q <= ((action_i == cteq_pkg::ACT_ADD) || (action_i == cteq_pkg::ACT_CANCEL))
                  ? event_id_in_i : '0;
    end else if (cmd_i.gen_id) begin
      id_q     <= gen_next;
      res_id_q <= gen_next;
    end else if (cmd_i.take) begin
      id_q     <= ra_q.id;
      res_id_q <= ra_q.id;
      res_hd_q <= ra_q.hd;
      last_q   <= rb_q;
      pos_q    <= '0;
    end else if (cmd_i.up_move) begin
      pos_q <= parent;
    end else if (cmd_i.dn_move) begin
      pos_q <= cidx;
    end
    if (cmd_i.finish) begin
      res_status_q <= cmd_i.status;
      res_kind_q   <= cmd_i.fire;
    end
    pidx_q <= sidx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      run_q      <= cteq_pkg::RUN_TERMINATED;
      last_gen_q <= '0;
      stamp_q    <= '0;
      valid_q    <= '0;
      issuing_q  <= 1'b0;
      pv_q       <= 1'b0;
      found_q    <= 1'b0;
      hfree_q    <= 1'b0;
      sidx_q     <= '0;
      fidx_q     <= '0;
      free_idx_q <= '0;
      done_q     <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
      if (cmd_i.set_run) begin
        run_q <= cmd_i.run;
      end
      if (cmd_i.gen_id) begin
        last_gen_q <= gen_next;
      end
      if (cmd_i.clear_all) begin
        count_q <= '0;
        valid_q <= '0;
      end else begin
        if (cmd_i.up_place) begin
          count_q <= count_q + CntW'(1);
          stamp_q <= stamp_q + IdW'(1);
        end else if (cmd_i.take) begin
          count_q <= count_q - CntW'(1);
        end
        if (cmd_i.clr_active) begin
          valid_q[fidx_q] <= 1'b0;
        end else if (cmd_i.mark && !found_q && hfree_q) begin
          valid_q[free_idx_q] <= 1'b1;
        end
      end
      // The scan reads one id slot per cycle and compares it in the cycle after the read.
      if (cmd_i.scan_start) begin
        sidx_q    <= '0;
        issuing_q <= 1'b1;
        pv_q      <= 1'b0;
        found_q   <= 1'b0;
        hfree_q   <= 1'b0;
      end else begin
        pv_q <= issuing_q;
        if (issuing_q) begin
          sidx_q <= sidx_q + IdxW'(1);
          if (sidx_q == IdxW'(QueueDepth - 1)) begin
            issuing_q <= 1'b0;
          end
        end
        if (pv_q) begin
          if (valid_q[pidx_q] && (rid_q == id_q) && !found_q) begin
            found_q <= 1'b1;
            fidx_q  <= pidx_q;
          end
          if (!valid_q[pidx_q] && !hfree_q) begin
            hfree_q    <= 1'b1;
            free_idx_q <= pidx_q;
          end
        end
      end
    end
  end

  always_comb begin
    sts_o.act       = act_q;
    sts_o.run       = run_q;
    sts_o.id_zero   = (id_q == '0);
    sts_o.cnt_zero  = (count_q == '0);
    sts_o.full      = (count_q == CntW'(QueueDepth));
    sts_o.scan_busy = issuing_q | pv_q;
    sts_o.found     = found_q;
    sts_o.at_root   = (pos_q == '0);
    sts_o.up_move   = earlier(nw, ra_q);
    sts_o.due       = (ra_q.dl <= now_q);
    sts_o.dn_leaf   = (lch >= cnt_ext);
    sts_o.dn_move   = earlier(child, last_q);
  end

  assign done_o         = done_q;
  assign status_o       = res_status_q;
  assign event_id_out_o = res_id_q;
  assign fire_kind_o    = res_kind_q;
  assign fired_handle_o = res_hd_q;

endmodule

// ===== rtl/cancellable_timer_event_queue_core.sv =====
// Top level of the cancellable timer event queue: controller plus datapath.
//
// Commands enter on start/action_i with their operands; a command transfer
// happens at a rising edge with start high and busy low. Exactly one result
// follows each command, shown for one cycle with done_o high; the receiver
// cannot stall and must take it in that cycle.
// Start, close, shutdown, undefined actions and rejected commands finish
// in the decode state, and done_o is registered from there. Cancel scans
// the active id store one slot per cycle. Add and a due tick also scan,
// then sift the heap one level at a time, with a read state and a compare
// state for each level. The id scan sets the rate.
// busy stays high until the result is produced, so one command is in flight.
// Reset empties the queue and the active set, clears the id and insertion
// counters and leaves the block terminated; the memories need no clearing.
module cancellable_timer_event_queue_core #(
  parameter int unsigned QueueDepth = cteq_pkg::QueueDepthDef,
  parameter int unsigned HandleBits = cteq_pkg::HandleBitsDef,
  parameter int unsigned TimeBits   = cteq_pkg::TimeBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  action_i,
  input  logic [TimeBits-1:0]         deadline_i,
  input  logic [cteq_pkg::IdBits-1:0] event_id_in_i,
  input  logic [HandleBits-1:0]       task_handle_i,
  input  logic [TimeBits-1:0]         now_time_i,
  output logic                        done_o,
  output logic [1:0]                  status_o,
  output logic [cteq_pkg::IdBits-1:0] event_id_out_o,
  output logic [1:0]                  fire_kind_o,
  output logic [HandleBits-1:0]       fired_handle_o
);

  cteq_pkg::cmd_t cmd;
  cteq_pkg::sts_t sts;

  cteq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  cteq_datapath #(
    .QueueDepth (QueueDepth),
    .HandleBits (HandleBits),
    .TimeBits   (TimeBits)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .action_i       (action_i),
    .deadline_i     (deadline_i),
    .event_id_in_i  (event_id_in_i),
    .task_handle_i  (task_handle_i),
    .now_time_i     (now_time_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .event_id_out_o (event_id_out_o),
    .fire_kind_o    (fire_kind_o),
    .fired_handle_o (fired_handle_o)
  );

`ifndef SYNTHESIS
  a_done_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while a command is still in progress");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted command did not make the block busy");

  a_fire_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (fire_kind_o != cteq_pkg::FIRE_NONE)) |-> (status_o == cteq_pkg::STS_OK))
    else $error("popped entry reported with a failing status");

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.up_place && !cmd.clear_all) |-> !sts.full)
    else $error("heap insert while the queue is full");
`endif

endmodule
